FILE: src/fwtp_pkg.sv
// Shared types and constants for the track format parser.
// No dependencies; used by every module of the block.
`default_nettype none

package fwtp_pkg;

    localparam logic [7:0] MARK_ID   = 8'hFE;
    localparam logic [7:0] MARK_DATA = 8'hFB;
    localparam logic [7:0] MARK_CRC  = 8'hF7;
    localparam logic [1:0] SIZE_CODE_MASK = 2'b11;

    localparam logic [6:0]  MAX_SECTORS = 7'd64;
    localparam logic [14:0] TRACK_BYTES = 15'd16384;
    localparam logic [10:0] BASE_SECTOR_SIZE = 11'd128;
    localparam logic [19:0] DD_RATE = 20'd500000;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_CLOSE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] REG_DATA_RATE    = 2'd0;
    localparam logic [1:0] REG_DISK_PRESENT = 2'd1;
    localparam logic [1:0] REG_TRACK_NUMBER = 2'd2;
    localparam logic [1:0] REG_SIDE_SELECT  = 2'd3;

    typedef enum logic [1:0] {
        PH_GAP  = 2'd0,
        PH_ID   = 2'd1,
        PH_SEEK = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    // Up to three results caused by one input item, emitted in field order.
    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic [8:0]  data_sector;
        logic        has_close;
        logic [8:0]  close_sector;
        logic [14:0] close_len;
        logic        has_sum;
        logic [6:0]  sum_count;
        logic [1:0]  sum_code;
        logic [7:0]  sum_start;
        logic        sum_found_ok;
    } t_bundle;

    typedef struct packed {
        logic [19:0] data_rate;
        logic        disk_present;
        logic [7:0]  track_number;
        logic        side_select;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/fwtp_parser.sv
// Parse state machine: updates track state per accepted byte and builds
// the result bundle for that byte. Depends on fwtp_pkg.
`default_nettype none

module fwtp_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_track_byte,
    input  wire logic             i_is_final,
    output fwtp_pkg::t_bundle     o_bundle
);

    fwtp_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [7:0]  r_pend_sec, n_pend_sec;
    logic [1:0]  r_pend_code, n_pend_code;
    logic [7:0]  r_first_start, n_first_start;
    logic [1:0]  r_first_code, n_first_code;
    logic [6:0]  r_fields, n_fields;
    logic [14:0] r_len, n_len;
    logic        r_too_many, n_too_many;

    logic close_a;
    logic do_close;
    logic [8:0] cur_sector;

    always_comb begin
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_pend_sec    = r_pend_sec;
        n_pend_code   = r_pend_code;
        n_first_start = r_first_start;
        n_first_code  = r_first_code;
        n_fields      = r_fields;
        n_len         = r_len;
        n_too_many    = r_too_many;
        close_a       = 1'b0;
        do_close      = 1'b0;
        cur_sector    = 9'd0;
        o_bundle      = '0;

        case (r_phase)
            fwtp_pkg::PH_GAP: begin
                if (i_track_byte == fwtp_pkg::MARK_ID) begin
                    n_phase = fwtp_pkg::PH_ID;
                    n_idx   = 2'd0;
                end
            end
            fwtp_pkg::PH_ID: begin
                if (r_idx == 2'd2) begin
                    n_pend_sec = i_track_byte;
                end
                if (r_idx == 2'd3) begin
                    n_pend_code = i_track_byte[1:0] & fwtp_pkg::SIZE_CODE_MASK;
                    n_phase     = fwtp_pkg::PH_SEEK;
                    n_idx       = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            fwtp_pkg::PH_SEEK: begin
                if (i_track_byte == fwtp_pkg::MARK_DATA) begin
                    if (r_fields == 7'd0) begin
                        n_first_start = r_pend_sec;
                        n_first_code  = r_pend_code;
                    end
                    if (r_fields >= fwtp_pkg::MAX_SECTORS) begin
                        n_too_many = 1'b1;
                    end
                    n_len   = 15'd0;
                    n_phase = fwtp_pkg::PH_DATA;
                end else if (i_track_byte == fwtp_pkg::MARK_ID) begin
                    n_phase = fwtp_pkg::PH_ID;
                    n_idx   = 2'd0;
                end
            end
            fwtp_pkg::PH_DATA: begin
                if (i_track_byte == fwtp_pkg::MARK_CRC) begin
                    close_a = 1'b1;
                end else begin
                    o_bundle.has_data  = 1'b1;
                    o_bundle.data_byte = i_track_byte;
                    if (r_len < fwtp_pkg::TRACK_BYTES) begin
                        n_len = r_len + 15'd1;
                    end
                end
            end
            default: begin
                n_phase = fwtp_pkg::PH_GAP;
            end
        endcase

        cur_sector = {1'b0, n_first_start} + {2'b00, r_fields};
        o_bundle.data_sector = cur_sector;

        // A final byte inside a data field closes it with what was seen.
        do_close = close_a || (i_is_final && (n_phase == fwtp_pkg::PH_DATA));
        if (do_close) begin
            o_bundle.has_close    = 1'b1;
            o_bundle.close_sector = cur_sector;
            o_bundle.close_len    = n_len;
            if (r_fields < fwtp_pkg::MAX_SECTORS) begin
                n_fields = r_fields + 7'd1;
            end
            n_len   = 15'd0;
            n_phase = fwtp_pkg::PH_GAP;
        end

        if (i_is_final) begin
            o_bundle.has_sum      = 1'b1;
            o_bundle.sum_count    = n_fields;
            o_bundle.sum_code     = n_first_code;
            o_bundle.sum_start    = n_first_start;
            o_bundle.sum_found_ok = (n_fields != 7'd0) && !n_too_many;
            n_phase       = fwtp_pkg::PH_GAP;
            n_idx         = 2'd0;
            n_pend_sec    = 8'd0;
            n_pend_code   = 2'd0;
            n_first_start = 8'd0;
            n_first_code  = 2'd0;
            n_fields      = 7'd0;
            n_len         = 15'd0;
            n_too_many    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= fwtp_pkg::PH_GAP;
            r_idx         <= 2'd0;
            r_pend_sec    <= 8'd0;
            r_pend_code   <= 2'd0;
            r_first_start <= 8'd0;
            r_first_code  <= 2'd0;
            r_fields      <= 7'd0;
            r_len         <= 15'd0;
            r_too_many    <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_idx         <= n_idx;
            r_pend_sec    <= n_pend_sec;
            r_pend_code   <= n_pend_code;
            r_first_start <= n_first_start;
            r_first_code  <= n_first_code;
            r_fields      <= n_fields;
            r_len         <= n_len;
            r_too_many    <= n_too_many;
        end
    end

endmodule

`default_nettype wire

FILE: src/fwtp_outbuf.sv
// Result register: holds one item's bundle and sends its results out
// one per handshake. Depends on fwtp_pkg.
`default_nettype none

module fwtp_outbuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire fwtp_pkg::t_bundle i_bundle,
    input  wire fwtp_pkg::t_cfg    i_cfg,
    output logic                   o_load_ok,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_data_byte,
    output logic [8:0]             o_sector_number,
    output logic [14:0]            o_field_length,
    output logic [6:0]             o_sector_count,
    output logic [10:0]            o_sector_size,
    output logic [7:0]             o_start_sector,
    output logic                   o_double_density,
    output logic                   o_track_ok,
    output logic [7:0]             o_out_track,
    output logic                   o_out_side,
    output logic                   o_last_result
);

    fwtp_pkg::t_bundle r_b;
    logic r_has_data, r_has_close, r_has_sum;
    logic n_has_data, n_has_close, n_has_sum;
    logic take;
    logic one_left;

    assign o_out_valid = r_has_data | r_has_close | r_has_sum;
    assign take        = o_out_valid & i_out_ready;
    assign one_left    = (r_has_data ^ r_has_close ^ r_has_sum)
                         & ~(r_has_data & r_has_close & r_has_sum);
    assign o_load_ok   = ~o_out_valid | (take & one_left);

    always_comb begin
        o_kind           = fwtp_pkg::KIND_DATA;
        o_data_byte      = 8'd0;
        o_sector_number  = 9'd0;
        o_field_length   = 15'd0;
        o_sector_count   = 7'd0;
        o_sector_size    = 11'd0;
        o_start_sector   = 8'd0;
        o_double_density = 1'b0;
        o_track_ok       = 1'b0;
        o_out_track      = i_cfg.track_number;
        o_out_side       = i_cfg.side_select;
        o_last_result    = one_left;
        if (r_has_data) begin
            o_kind          = fwtp_pkg::KIND_DATA;
            o_data_byte     = r_b.data_byte;
            o_sector_number = r_b.data_sector;
        end else if (r_has_close) begin
            o_kind          = fwtp_pkg::KIND_CLOSE;
            o_sector_number = r_b.close_sector;
            o_field_length  = r_b.close_len;
        end else if (r_has_sum) begin
            o_kind           = fwtp_pkg::KIND_SUMMARY;
            o_sector_count   = r_b.sum_count;
            o_sector_size    = fwtp_pkg::BASE_SECTOR_SIZE << r_b.sum_code;
            o_start_sector   = r_b.sum_start;
            o_double_density = i_cfg.data_rate >= fwtp_pkg::DD_RATE;
            o_track_ok       = i_cfg.disk_present & r_b.sum_found_ok;
        end
    end

    always_comb begin
        n_has_data  = r_has_data;
        n_has_close = r_has_close;
        n_has_sum   = r_has_sum;
        if (take) begin
            if (r_has_data) begin
                n_has_data = 1'b0;
            end else if (r_has_close) begin
                n_has_close = 1'b0;
            end else begin
                n_has_sum = 1'b0;
            end
        end
        if (i_load) begin
            n_has_data  = i_bundle.has_data;
            n_has_close = i_bundle.has_close;
            n_has_sum   = i_bundle.has_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_data  <= 1'b0;
            r_has_close <= 1'b0;
            r_has_sum   <= 1'b0;
        end else begin
            r_has_data  <= n_has_data;
            r_has_close <= n_has_close;
            r_has_sum   <= n_has_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= i_bundle;
        end
    end

endmodule

`default_nettype wire

FILE: src/floppy_write_track_parser.sv
// Top level of the track format parser: configuration registers, parser
// and result register. Depends on fwtp_pkg, fwtp_parser, fwtp_outbuf.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one raw track byte per
//   item with i_is_final set on the last byte of the track.
//   Output channel (o_out_valid / i_out_ready) carries results: data bytes,
//   end-of-field reports and one track summary after the final byte.
//   Each byte is parsed in the cycle it is accepted; its results sit in the
//   result register from the next cycle. A byte causes zero to three results.
//   Results leave one per cycle while the receiver is ready, and a new byte is
//   taken in the same cycle the last pending result is taken, so throughput
//   is one byte per cycle while each byte yields at most one result and the
//   receiver is ready; more results hold the input until the last is taken.
//   When the receiver stalls, the pending results hold and o_in_ready drops
//   once the result register cannot be emptied in that cycle.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   once; write only while the block is idle.
//   Reset clears the parse state, empties the result register and sets the
//   registers to data rate 250000, no disk, track 0, side 0.
`default_nettype none

module floppy_write_track_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_track_byte,
    input  wire logic        i_is_final,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [8:0]       o_sector_number,
    output logic [14:0]      o_field_length,
    output logic [6:0]       o_sector_count,
    output logic [10:0]      o_sector_size,
    output logic [7:0]       o_start_sector,
    output logic             o_double_density,
    output logic             o_track_ok,
    output logic [7:0]       o_out_track,
    output logic             o_out_side,
    output logic             o_last_result
);

    fwtp_pkg::t_cfg    r_cfg;
    fwtp_pkg::t_bundle bundle;
    logic              accept;

    assign accept = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_rate    <= 20'd250000;
            r_cfg.disk_present <= 1'b0;
            r_cfg.track_number <= 8'd0;
            r_cfg.side_select  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fwtp_pkg::REG_DATA_RATE:    r_cfg.data_rate    <= i_cfg_data;
                fwtp_pkg::REG_DISK_PRESENT: r_cfg.disk_present <= i_cfg_data[0];
                fwtp_pkg::REG_TRACK_NUMBER: r_cfg.track_number <= i_cfg_data[7:0];
                fwtp_pkg::REG_SIDE_SELECT:  r_cfg.side_select  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fwtp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_track_byte (i_track_byte),
        .i_is_final   (i_is_final),
        .o_bundle     (bundle)
    );

    fwtp_outbuf u_outbuf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (accept),
        .i_bundle         (bundle),
        .i_cfg            (r_cfg),
        .o_load_ok        (o_in_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_sector_number  (o_sector_number),
        .o_field_length   (o_field_length),
        .o_sector_count   (o_sector_count),
        .o_sector_size    (o_sector_size),
        .o_start_sector   (o_start_sector),
        .o_double_density (o_double_density),
        .o_track_ok       (o_track_ok),
        .o_out_track      (o_out_track),
        .o_out_side       (o_out_side),
        .o_last_result    (o_last_result)
    );

endmodule

`default_nettype wire
